// ===== rtl/mbp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbp_pkg
// shared constants and types of the msb-first bit packer
// ----------------------------------------------------------------------------
`default_nettype none

package mbp_pkg;

  localparam int MAX_CODE_BITS = 16;
  localparam int FIELD_BITS    = 16;
  localparam int BYTE_BITS     = 8;
  localparam int LEN_W         = 5;
  localparam int HOLD_W        = 7;
  localparam int CNT_W         = 3;
  localparam int ACC_W         = HOLD_W + FIELD_BITS;

  localparam int LEN_LIMIT_INT = (MAX_CODE_BITS < FIELD_BITS) ? MAX_CODE_BITS : FIELD_BITS;
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_LIMIT_INT);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_FLUSH = 1'b1
  } action_t;

  // one to two finished bytes caused by a single input beat
  typedef struct packed {
    logic                 two;
    logic [BYTE_BITS-1:0] first;
    logic [BYTE_BITS-1:0] second;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/mbp_in_if.sv =====
// ----------------------------------------------------------------------------
// mbp_in_if
// code channel: action, code bits and length
// ----------------------------------------------------------------------------
`default_nettype none

interface mbp_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] code_value;
  logic [4:0]  code_length;

  modport source (output valid, output action, output code_value, output code_length,
                  input ready);
  modport sink (input valid, input action, input code_value, input code_length,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/mbp_out_if.sv =====
// ----------------------------------------------------------------------------
// mbp_out_if
// byte channel: packed byte and end-of-run mark
// ----------------------------------------------------------------------------
`default_nettype none

interface mbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/mbp_front.sv =====
// ----------------------------------------------------------------------------
// mbp_front
// accepts code beats, merges them with the held bits and emits byte jobs
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_front
  import mbp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  mbp_in_if.sink     din,
  input  wire logic  q_full,
  output logic       push,
  output job_t       job
);

  logic [HOLD_W-1:0]     pending_bits, pending_bits_next;
  logic [CNT_W-1:0]      pending_count, pending_count_next;

  logic                  accept;
  logic [LEN_W-1:0]      len;
  logic [FIELD_BITS:0]   wide_mask;
  logic [FIELD_BITS-1:0] code;
  logic [ACC_W-1:0]      acc;
  logic [LEN_W-1:0]      total;
  logic [LEN_W-1:0]      sh_first;
  logic [LEN_W-1:0]      sh_second;
  logic [ACC_W-1:0]      acc_first;
  logic [ACC_W-1:0]      acc_second;
  logic [CNT_W-1:0]      rest;
  logic [HOLD_W-1:0]     rest_mask;
  logic [BYTE_BITS-1:0]  flush_byte;
  logic [CNT_W:0]        pad;

  assign din.ready = !q_full;
  assign accept    = din.valid && din.ready;

  always_comb begin
    len        = (din.code_length > LEN_LIMIT) ? LEN_LIMIT : din.code_length;
    wide_mask  = ~({(FIELD_BITS+1){1'b1}} << len);
    code       = din.code_value & wide_mask[FIELD_BITS-1:0];
    acc        = (ACC_W'(pending_bits) << len) | ACC_W'(code);
    total      = LEN_W'(pending_count) + len;
    sh_first   = total - LEN_W'(BYTE_BITS);
    sh_second  = total - LEN_W'(2 * BYTE_BITS);
    acc_first  = acc >> sh_first;
    acc_second = acc >> sh_second;
    rest       = total[CNT_W-1:0];
    rest_mask  = ~({HOLD_W{1'b1}} << rest);
    pad        = (CNT_W+1)'(BYTE_BITS) - {1'b0, pending_count};
    flush_byte = 8'((BYTE_BITS+HOLD_W)'(pending_bits) << pad);

    push               = 1'b0;
    job.two            = 1'b0;
    job.first          = acc_first[BYTE_BITS-1:0];
    job.second         = acc_second[BYTE_BITS-1:0];
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;

    if (accept) begin
      case (action_t'(din.action))
        ACT_FLUSH: begin
          if (pending_count != '0) begin
            push      = 1'b1;
            job.first = flush_byte;
          end
          pending_bits_next  = '0;
          pending_count_next = '0;
        end
        ACT_WRITE: begin
          if (total >= LEN_W'(BYTE_BITS)) begin
            push    = 1'b1;
            job.two = (total >= LEN_W'(2 * BYTE_BITS));
          end
          pending_bits_next  = acc[HOLD_W-1:0] & rest_mask;
          pending_count_next = rest;
        end
        default: begin
          pending_bits_next  = pending_bits;
          pending_count_next = pending_count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mbp_queue.sv =====
// ----------------------------------------------------------------------------
// mbp_queue
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_queue
  import mbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output job_t      head
);

  job_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] fill;

  assign full  = (fill == Q_CNT_W'(Q_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + Q_CNT_W'(push && !full) - Q_CNT_W'(pop && !empty);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mbp_back.sv =====
// ----------------------------------------------------------------------------
// mbp_back
// drains byte jobs one byte per beat into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_back
  import mbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  input  job_t      head,
  output logic      pop,
  mbp_out_if.source dout
);

  logic                 hold_second;
  logic [BYTE_BITS-1:0] second_byte;
  logic                 load;

  assign load = !dout.valid || dout.ready;
  assign pop  = load && !hold_second && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid  <= 1'b0;
      hold_second <= 1'b0;
    end else if (load) begin
      if (hold_second) begin
        dout.valid  <= 1'b1;
        hold_second <= 1'b0;
      end else if (!q_empty) begin
        dout.valid  <= 1'b1;
        hold_second <= head.two;
      end else begin
        dout.valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (hold_second) begin
        dout.out_byte    <= second_byte;
        dout.last_of_run <= 1'b1;
      end else begin
        dout.out_byte    <= head.first;
        dout.last_of_run <= !head.two;
        second_byte      <= head.second;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/msb_first_bit_packer.sv =====
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// packs variable-length codes msb first into a byte stream
// ----------------------------------------------------------------------------
// din carries one beat per code: action selects append or flush, code_length
// (saturated to 16) low bits of code_value are appended behind the held bits.
// dout carries the finished bytes, first written bit in bit 7; last_of_run
// marks the final byte caused by one din beat. a write causes zero to two
// bytes, a flush one zero-padded byte if any bits are held.
// the front accepts a beat every cycle while the two-entry job queue has room
// and updates the held bits at once. the first byte of a beat passes through
// the job queue and the output register on its way to dout. dout runs at one
// byte per cycle while dout.ready holds, so a sustained mix of two-byte codes
// is paced by dout. when dout stalls, the queue fills and din.ready drops.
// reset clears the held bits, the queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_first_bit_packer
  import mbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  mbp_in_if.sink    din,
  mbp_out_if.source dout
);

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t head;

  mbp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .din    (din),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  mbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  mbp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .dout    (dout)
  );

endmodule

`default_nettype wire

// ===== rtl/mbp_checker.sv =====
// ----------------------------------------------------------------------------
// mbp_checker
// port-level checks of the bit packer over time
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       last_of_run
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("output beat changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // second byte of a pair follows directly
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("second byte of a pair missing");

  // input is ready in the cycle right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready after reset");

  // waiting input beat stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input beat withdrawn while waiting");

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (din.valid),
  .in_ready    (din.ready),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .out_byte    (dout.out_byte),
  .last_of_run (dout.last_of_run)
);

`default_nettype wire
